// ===== sv/chained_hash_table_engine_macros.svh =====
// Assertion helpers for the checker file
`ifndef CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_MACROS_SVH

// same-cycle implication
`define CHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cht_pkg.sv =====
package cht_pkg;

    localparam int CFG_W = 11;
    localparam int KEY_W = 64;
    localparam int VAL_W = 32;
    localparam int CNT_W = 9;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [CFG_W-1:0] BUCKETS_RST = 11'd16;

    localparam logic [63:0] MIX_C1 = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_C2 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C3 = 64'h94d049bb133111eb;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] data_out;
        logic [CNT_W-1:0] item_count;
        logic             full_res;
    } res_t;

endpackage

// ===== sv/cht_front.sv =====
module cht_front #(
    parameter int MAX_BUCKETS = 1024,
    parameter int BW          = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cht_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        enable,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cht_pkg::req_t               in_req,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cht_pkg::req_t               out_req,
    output logic [BW-1:0]               out_bucket
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_MOD, F_PUSH} fstate_t;

    fstate_t                    state_reg;
    logic [cht_pkg::CFG_W-1:0]  bc_reg;
    logic [cht_pkg::CFG_W-1:0]  n_eff;
    cht_pkg::req_t              req_reg;
    logic [63:0]                x_reg;
    logic [63:0]                acc_reg;
    logic [63:0]                acc_next;
    logic [63:0]                div_reg;
    logic [63:0]                z0;
    logic [1:0]                 phase_reg;
    logic                       round_reg;
    logic [3:0]                 cnt_reg;
    logic [cht_pkg::CFG_W-1:0]  rem_reg;
    logic [cht_pkg::CFG_W-1:0]  rem_next;
    logic [cht_pkg::CFG_W-1:0]  r;
    logic [cht_pkg::CFG_W:0]    t;
    logic [31:0]                mul_a;
    logic [31:0]                mul_b;
    logic [63:0]                kc;
    logic [63:0]                prod;

    assign cfg_ready  = 1'b1;
    assign in_ready   = enable && (state_reg == F_IDLE);
    assign out_valid  = (state_reg == F_PUSH);
    assign out_req    = req_reg;
    assign out_bucket = BW'(rem_reg);

    always_comb begin
        if (bc_reg == '0) begin
            n_eff = cht_pkg::CFG_W'(1);
        end else if (32'(bc_reg) > 32'(MAX_BUCKETS)) begin
            n_eff = cht_pkg::CFG_W'(MAX_BUCKETS);
        end else begin
            n_eff = bc_reg;
        end
    end

    assign z0 = in_req.key + cht_pkg::MIX_C1;

    // 64x64 low product from three 32x32 partial products, one per cycle
    always_comb begin
        kc    = round_reg ? cht_pkg::MIX_C3 : cht_pkg::MIX_C2;
        mul_a = (phase_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
        mul_b = (phase_reg == 2'd1) ? kc[63:32] : kc[31:0];
        prod  = 64'(mul_a) * 64'(mul_b);
        if (phase_reg == 2'd0) begin
            acc_next = prod;
        end else begin
            acc_next = acc_reg + {prod[31:0], 32'd0};
        end
    end

    // four restoring remainder steps per cycle
    always_comb begin
        r = rem_reg;
        t = '0;
        for (int i = 0; i < 4; i++) begin
            t = {r, div_reg[63-i]};
            if (t >= {1'b0, n_eff}) begin
                t = t - {1'b0, n_eff};
            end
            r = t[cht_pkg::CFG_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            bc_reg    <= cht_pkg::BUCKETS_RST;
            phase_reg <= '0;
            round_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                bc_reg <= cfg_data;
            end
            unique case (state_reg)
                F_IDLE: begin
                    if (in_valid && in_ready) begin
                        req_reg   <= in_req;
                        x_reg     <= z0 ^ (z0 >> 30);
                        phase_reg <= '0;
                        round_reg <= 1'b0;
                        state_reg <= F_MUL;
                    end
                end
                F_MUL: begin
                    acc_reg <= acc_next;
                    if (phase_reg == 2'd2) begin
                        phase_reg <= '0;
                        if (!round_reg) begin
                            x_reg     <= acc_next ^ (acc_next >> 27);
                            round_reg <= 1'b1;
                        end else begin
                            div_reg   <= acc_next ^ (acc_next >> 31);
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= F_MOD;
                        end
                    end else begin
                        phase_reg <= phase_reg + 2'd1;
                    end
                end
                F_MOD: begin
                    rem_reg <= rem_next;
                    div_reg <= {div_reg[59:0], 4'd0};
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (out_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/cht_fifo.sv =====
module cht_fifo #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic [W-1:0] mem_reg [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;
    logic         push;
    logic         pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== sv/cht_back.sv =====
module cht_back #(
    parameter int MAX_BUCKETS = 1024,
    parameter int NODE_COUNT  = 256,
    parameter int DATA_BITS   = 32,
    parameter int BW          = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    output logic          init_done,
    input  logic          in_valid,
    output logic          in_ready,
    input  cht_pkg::req_t in_req,
    input  logic [BW-1:0] in_bucket,
    output logic          m_valid,
    input  logic          m_ready,
    output cht_pkg::res_t m_res
);

    localparam int LW = $clog2(NODE_COUNT + 1);
    localparam int NW = $clog2(NODE_COUNT);
    localparam int DW = (DATA_BITS < cht_pkg::VAL_W) ? DATA_BITS : cht_pkg::VAL_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(NODE_COUNT);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HEAD, S_HLOAD, S_WALK, S_CHECK, S_END, S_ALLOC, S_LINK, S_DONE
    } bstate_t;

    logic [LW-1:0]    head_mem [MAX_BUCKETS];
    logic [63:0]      hash_mem [NODE_COUNT];
    logic [DW-1:0]    data_mem [NODE_COUNT];
    logic [LW-1:0]    next_mem [NODE_COUNT];
    logic [NW-1:0]    fs_mem   [NODE_COUNT];

    logic [LW-1:0]    head_q;
    logic [63:0]      hash_q;
    logic [DW-1:0]    data_q;
    logic [LW-1:0]    next_q;
    logic [NW-1:0]    fs_q;

    bstate_t          state_reg;
    logic [BW-1:0]    clr_reg;
    logic [1:0]       cmd_reg;
    logic [63:0]      key_reg;
    logic [DW-1:0]    val_reg;
    logic [BW-1:0]    bucket_reg;
    logic [LW-1:0]    cur_reg;
    logic [NW-1:0]    prev_reg;
    logic             prev_head_reg;
    logic [LW-1:0]    link_reg;
    logic             found_reg;
    logic [DW-1:0]    dout_reg;
    logic             full_reg;
    logic [LW-1:0]    used_reg;
    logic [LW-1:0]    hwm_reg;
    logic             out_valid_reg;
    cht_pkg::res_t    out_reg;

    logic             head_we;
    logic [BW-1:0]    head_waddr;
    logic [LW-1:0]    head_wdata;
    logic             nd_we;
    logic [NW-1:0]    nd_addr;
    logic             nx_we;
    logic [NW-1:0]    nx_addr;
    logic [LW-1:0]    nx_wdata;
    logic             fs_we;
    logic [LW-1:0]    used_dec;
    logic [NW-1:0]    cur_idx;
    logic [NW-1:0]    alloc_idx;
    logic             hit;

    assign init_done = (state_reg != S_CLEAR);
    assign in_ready  = (state_reg == S_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_res     = out_reg;
    assign cur_idx   = cur_reg[NW-1:0];
    assign used_dec  = used_reg - LW'(1);
    assign hit       = (hash_q == key_reg);
    // at or above the high-water mark no node was ever freed, so used_reg itself is the next free index
    assign alloc_idx = (used_reg < hwm_reg) ? fs_q : used_reg[NW-1:0];

    always_comb begin
        head_we    = 1'b0;
        head_waddr = bucket_reg;
        head_wdata = link_reg;
        nd_we      = 1'b0;
        nd_addr    = cur_idx;
        nx_we      = 1'b0;
        nx_addr    = prev_reg;
        nx_wdata   = link_reg;
        fs_we      = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = NULL_LINK;
            end
            S_CHECK: begin
                if (cmd_reg == cht_pkg::CMD_INSERT && (data_q == '0 || hit)) begin
                    nd_we = 1'b1;
                end else if (cmd_reg == cht_pkg::CMD_REMOVE && hit && used_reg != '0) begin
                    fs_we = 1'b1;
                end
            end
            S_ALLOC: begin
                nd_we    = 1'b1;
                nd_addr  = alloc_idx;
                nx_we    = 1'b1;
                nx_addr  = alloc_idx;
                nx_wdata = NULL_LINK;
            end
            S_LINK: begin
                if (prev_head_reg) begin
                    head_we = 1'b1;
                end else begin
                    nx_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_q <= head_mem[bucket_reg];
    end

    always_ff @(posedge aclk) begin
        if (nd_we) begin
            hash_mem[nd_addr] <= key_reg;
        end
        hash_q <= hash_mem[cur_idx];
    end

    always_ff @(posedge aclk) begin
        if (nd_we) begin
            data_mem[nd_addr] <= val_reg;
        end
        data_q <= data_mem[cur_idx];
    end

    always_ff @(posedge aclk) begin
        if (nx_we) begin
            next_mem[nx_addr] <= nx_wdata;
        end
        next_q <= next_mem[cur_idx];
    end

    always_ff @(posedge aclk) begin
        if (fs_we) begin
            fs_mem[used_dec[NW-1:0]] <= cur_idx;
        end
        fs_q <= fs_mem[used_reg[NW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            hwm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready && state_reg != S_DONE) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + BW'(1);
                    if (clr_reg == BW'(MAX_BUCKETS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_valid) begin
                        cmd_reg    <= in_req.cmd;
                        key_reg    <= in_req.key;
                        val_reg    <= in_req.value[DW-1:0];
                        bucket_reg <= in_bucket;
                        found_reg  <= 1'b0;
                        dout_reg   <= '0;
                        full_reg   <= 1'b0;
                        if (in_req.cmd == cht_pkg::CMD_INSERT
                            || in_req.cmd == cht_pkg::CMD_REMOVE
                            || in_req.cmd == cht_pkg::CMD_LOOKUP) begin
                            state_reg <= S_HEAD;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_HEAD: state_reg <= S_HLOAD;
                S_HLOAD: begin
                    cur_reg       <= head_q;
                    prev_head_reg <= 1'b1;
                    state_reg     <= S_WALK;
                end
                S_WALK: begin
                    if (cur_reg < NULL_LINK) begin
                        state_reg <= S_CHECK;
                    end else begin
                        state_reg <= S_END;
                    end
                end
                S_CHECK: begin
                    priority if (cmd_reg == cht_pkg::CMD_INSERT && (data_q == '0 || hit)) begin
                        state_reg <= S_DONE;
                    end else if (cmd_reg == cht_pkg::CMD_REMOVE && hit) begin
                        link_reg  <= next_q;
                        found_reg <= 1'b1;
                        if (used_reg != '0) begin
                            used_reg <= used_dec;
                        end
                        state_reg <= S_LINK;
                    end else if (cmd_reg == cht_pkg::CMD_LOOKUP && hit) begin
                        found_reg <= 1'b1;
                        dout_reg  <= data_q;
                        state_reg <= S_DONE;
                    end else begin
                        prev_reg      <= cur_idx;
                        prev_head_reg <= 1'b0;
                        cur_reg       <= next_q;
                        state_reg     <= S_WALK;
                    end
                end
                S_END: begin
                    if (cmd_reg != cht_pkg::CMD_INSERT) begin
                        state_reg <= S_DONE;
                    end else if (used_reg >= NULL_LINK) begin
                        full_reg  <= 1'b1;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    link_reg <= LW'(alloc_idx);
                    used_reg <= used_reg + LW'(1);
                    if (used_reg >= hwm_reg) begin
                        hwm_reg <= used_reg + LW'(1);
                    end
                    state_reg <= S_LINK;
                end
                S_LINK: state_reg <= S_DONE;
                S_DONE: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg       <= 1'b1;
                        out_reg.found       <= found_reg;
                        out_reg.data_out    <= cht_pkg::VAL_W'(dout_reg);
                        out_reg.item_count  <= cht_pkg::CNT_W'(used_reg);
                        out_reg.full_res    <= full_reg;
                        state_reg           <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/chained_hash_table_engine.sv =====
// Chained hash table: insert, remove and lookup requests keyed by a 64-bit prehash, one result
// per request. The front end takes a request, runs the two splitmix64 multiplies (three 32x32
// partial products each) and the bucket remainder at four bits a cycle, then hands it to a
// two-entry queue; it takes no new request until the last one is handed on. The back end walks
// the chain in node memories with registered reads: a head read, a check per node visited, an
// end state when the walk finds no match, a link step to unlink and an alloc and a link step to
// append. The front-end remainder unit sets the sustained rate for short chains, the chain walk
// for long ones. After reset the bucket heads are cleared one a cycle and s_tready stays low
// until that is done; bucket_count may be written meanwhile.
module chained_hash_table_engine #(
    parameter int MAX_BUCKETS = 1024,
    parameter int NODE_COUNT  = 256,
    parameter int DATA_BITS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // key_hash [63:0], data_value [95:64]
    input  logic [1:0]  s_tuser,   // cmd [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // found [0], data_out [32:1], item_count [41:33],
                                   // full_res [42], zero [47:43]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data   // bucket_count
);

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int QW = $bits(cht_pkg::req_t) + BW;

    cht_pkg::req_t  s_req;
    cht_pkg::req_t  f_req;
    cht_pkg::req_t  b_req;
    cht_pkg::res_t  res;
    logic [BW-1:0]  f_bucket;
    logic [BW-1:0]  b_bucket;
    logic           f_valid;
    logic           f_ready;
    logic           q_valid;
    logic           q_ready;
    logic           init_done;
    logic [QW-1:0]  q_out;

    assign s_req.cmd   = s_tuser;
    assign s_req.key   = s_tdata[63:0];
    assign s_req.value = s_tdata[95:64];

    assign b_req    = q_out[QW-1:BW];
    assign b_bucket = q_out[BW-1:0];

    assign m_tdata = {5'd0, res.full_res, res.item_count, res.data_out, res.found};

    cht_front #(
        .MAX_BUCKETS(MAX_BUCKETS),
        .BW         (BW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .enable    (init_done),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_req),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_req   (f_req),
        .out_bucket(f_bucket)
    );

    cht_fifo #(
        .W(QW)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  ({f_req, f_bucket}),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_out)
    );

    cht_back #(
        .MAX_BUCKETS(MAX_BUCKETS),
        .NODE_COUNT (NODE_COUNT),
        .DATA_BITS  (DATA_BITS),
        .BW         (BW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .init_done(init_done),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_req   (b_req),
        .in_bucket(b_bucket),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (res)
    );

endmodule

// ===== sv/cht_checker.sv =====
`include "chained_hash_table_engine_macros.svh"

module cht_checker #(
    parameter int NODE_COUNT = 256
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    `CHT_ASSERT_NEXT(a_res_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a full flag only when every node is taken
    `CHT_ASSERT_NOW(a_full_count, m_tvalid && m_tdata[42], m_tdata[41:33] == 9'(NODE_COUNT), "full reported with free nodes")

    `CHT_ASSERT_NOW(a_found_full, m_tvalid, !(m_tdata[0] && m_tdata[42]), "found and full together")

    `CHT_ASSERT_NOW(a_data_miss, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0, "data returned without a hit")

endmodule

bind chained_hash_table_engine cht_checker #(.NODE_COUNT(NODE_COUNT)) u_cht_checker (.*);

// ===== bench/chained_hash_table_engine_test.sv =====
`timescale 1ns / 1ps

module chained_hash_table_engine_test;

    localparam int MAX_BUCKETS = 1024;
    localparam int NODE_COUNT  = 256;
    localparam int NULL_LINK   = NODE_COUNT;
    localparam int IDLE_LIMIT  = 40000;
    localparam int N_KEYS      = 24;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // key_hash [63:0], data_value [95:64]
    logic [1:0]  s_tuser = '0;   // cmd [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // found [0], data_out [32:1], item_count [41:33], full_res [42]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;  // bucket_count

    always #5 aclk = ~aclk;

    chained_hash_table_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // table shadow
    logic [cht_pkg::CFG_W-1:0] buckets_cfg;
    int unsigned      head_link [MAX_BUCKETS];
    logic [63:0]      shadow_hash [NODE_COUNT];
    logic [31:0]      shadow_data [NODE_COUNT];
    int unsigned      shadow_next [NODE_COUNT];
    int unsigned      free_pool [NODE_COUNT];
    int unsigned      nodes_taken;

    cht_pkg::res_t pending_results [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          n_sent = 0, n_recv = 0, n_full = 0, n_hits = 0;
    int          burst_left = 0;
    int unsigned cyc = 0;
    logic [63:0] key_pool [N_KEYS];

    function automatic logic [63:0] splitmix(logic [63:0] z);
        z = z + cht_pkg::MIX_C1;
        z = (z ^ (z >> 30)) * cht_pkg::MIX_C2;
        z = (z ^ (z >> 27)) * cht_pkg::MIX_C3;
        return z ^ (z >> 31);
    endfunction

    function automatic cht_pkg::res_t table_apply(logic [1:0] cmd, logic [63:0] key,
                                                  logic [31:0] val);
        cht_pkg::res_t r;
        int unsigned nb, b, n, prev, steps;
        logic        done;
        r = '0;
        nb = buckets_cfg;
        if (nb == 0) nb = 1;
        if (nb > MAX_BUCKETS) nb = MAX_BUCKETS;
        b = 32'(splitmix(key) % 64'(nb));
        n = head_link[b];
        prev = NULL_LINK;   // NULL_LINK here means the link is the bucket head
        steps = 0;
        done = 1'b0;
        if (cmd == cht_pkg::CMD_INSERT) begin
            while (n < NODE_COUNT && steps < NODE_COUNT && !done) begin
                if (shadow_data[n] == 0 || shadow_hash[n] == key) begin
                    shadow_hash[n] = key;
                    shadow_data[n] = val;
                    done = 1'b1;
                end else begin
                    prev = n;
                    n = shadow_next[n];
                    steps++;
                end
            end
            if (!done) begin
                if (nodes_taken >= NODE_COUNT) begin
                    r.full_res = 1'b1;
                end else begin
                    n = free_pool[nodes_taken] % NODE_COUNT;
                    nodes_taken++;
                    shadow_hash[n] = key;
                    shadow_data[n] = val;
                    shadow_next[n] = NULL_LINK;
                    if (prev == NULL_LINK) head_link[b] = n;
                    else shadow_next[prev] = n;
                end
            end
        end else if (cmd == cht_pkg::CMD_REMOVE) begin
            while (n < NODE_COUNT && steps < NODE_COUNT && !done) begin
                if (shadow_hash[n] == key) begin
                    if (prev == NULL_LINK) head_link[b] = shadow_next[n];
                    else shadow_next[prev] = shadow_next[n];
                    if (nodes_taken > 0) begin
                        nodes_taken--;
                        free_pool[nodes_taken] = n;
                    end
                    r.found = 1'b1;
                    done = 1'b1;
                end else begin
                    prev = n;
                    n = shadow_next[n];
                    steps++;
                end
            end
        end else if (cmd == cht_pkg::CMD_LOOKUP) begin
            while (n < NODE_COUNT && steps < NODE_COUNT && !done) begin
                if (shadow_hash[n] == key) begin
                    r.found = 1'b1;
                    r.data_out = shadow_data[n];
                    done = 1'b1;
                end else begin
                    n = shadow_next[n];
                    steps++;
                end
            end
        end
        r.item_count = nodes_taken[cht_pkg::CNT_W-1:0];
        return r;
    endfunction

    // one request; bursts of random length separated by random gaps
    task automatic send_request(logic [1:0] cmd, logic [63:0] key, logic [31:0] val,
                                logic use_typed, cht_pkg::res_t typed);
        cht_pkg::res_t r;
        int            gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {val, key};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        r = table_apply(cmd, key, val);
        pending_results.push_back(use_typed ? typed : r);
        n_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_buckets(logic [10:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        buckets_cfg = v;
    endtask

    task automatic random_request(int unsigned key_bias);
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [31:0] val;
        int unsigned w;
        w = $urandom_range(0, 99);
        if (w < 40) cmd = cht_pkg::CMD_INSERT;
        else if (w < 65) cmd = cht_pkg::CMD_REMOVE;
        else if (w < 95) cmd = cht_pkg::CMD_LOOKUP;
        else cmd = CMD_UNUSED;
        if ($urandom_range(0, 99) < key_bias) key = key_pool[$urandom_range(0, N_KEYS - 1)];
        else key = {$urandom, $urandom};
        val = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
        send_request(cmd, key, val, 1'b0, '0);
    endtask

    // receiver stalls: mostly ready, with a recurring window of random ready
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        m_tready <= ((cyc % 64) < 40) ? 1'b1 : ($urandom_range(0, 2) == 0);
    end

    always @(posedge aclk) begin
        cht_pkg::res_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            n_recv++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: %h", $time, m_tdata);
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r.found) n_hits++;
                if (exp_r.full_res) n_full++;
                if (m_tdata[0] !== exp_r.found) begin
                    errors++;
                    $display("%0t: found exp %b got %b", $time, exp_r.found, m_tdata[0]);
                end
                if (m_tdata[32:1] !== exp_r.data_out) begin
                    errors++;
                    $display("%0t: data_out exp %h got %h", $time, exp_r.data_out,
                             m_tdata[32:1]);
                end
                if (m_tdata[41:33] !== exp_r.item_count) begin
                    errors++;
                    $display("%0t: item_count exp %0d got %0d", $time, exp_r.item_count,
                             m_tdata[41:33]);
                end
                if (m_tdata[42] !== exp_r.full_res) begin
                    errors++;
                    $display("%0t: full_res exp %b got %b", $time, exp_r.full_res,
                             m_tdata[42]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    typedef struct {
        logic [1:0]    cmd;
        logic [63:0]   key;
        logic [31:0]   val;
        logic          typed;
        cht_pkg::res_t r;
    } step_row_t;

    localparam logic [63:0] K0 = 64'd0;
    localparam logic [63:0] K1 = 64'hFFFF_FFFF_FFFF_FFFF;

    step_row_t directed [] = '{
        '{cht_pkg::CMD_LOOKUP, K0, 32'd0,         1'b1, '{1'b0, 32'd0,         9'd0, 1'b0}},
        '{cht_pkg::CMD_REMOVE, K1, 32'd0,         1'b1, '{1'b0, 32'd0,         9'd0, 1'b0}},
        '{CMD_UNUSED,          K1, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0,         9'd0, 1'b0}},
        '{cht_pkg::CMD_INSERT, K0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0,         9'd1, 1'b0}},
        '{cht_pkg::CMD_LOOKUP, K0, 32'd0,         1'b1, '{1'b1, 32'hFFFF_FFFF, 9'd1, 1'b0}},
        '{cht_pkg::CMD_INSERT, K1, 32'd1,         1'b1, '{1'b0, 32'd0,         9'd2, 1'b0}},
        '{cht_pkg::CMD_LOOKUP, K1, 32'd0,         1'b1, '{1'b1, 32'd1,         9'd2, 1'b0}},
        '{cht_pkg::CMD_INSERT, K0, 32'd5,         1'b1, '{1'b0, 32'd0,         9'd2, 1'b0}},
        '{cht_pkg::CMD_LOOKUP, K0, 32'hAAAA_5555, 1'b1, '{1'b1, 32'd5,         9'd2, 1'b0}},
        '{cht_pkg::CMD_INSERT, K0, 32'd0,         1'b1, '{1'b0, 32'd0,         9'd2, 1'b0}},
        '{cht_pkg::CMD_LOOKUP, K0, 32'd0,         1'b1, '{1'b1, 32'd0,         9'd2, 1'b0}},
        '{cht_pkg::CMD_INSERT, 64'd1, 32'd7,      1'b0, '0},
        '{CMD_UNUSED,          64'd1, 32'd9,      1'b0, '0},
        '{cht_pkg::CMD_LOOKUP, 64'd1, 32'd0,      1'b0, '0},
        '{cht_pkg::CMD_REMOVE, K1, 32'd0,         1'b0, '0},
        '{cht_pkg::CMD_REMOVE, K1, 32'd0,         1'b0, '0},
        '{cht_pkg::CMD_LOOKUP, K1, 32'd0,         1'b0, '0},
        '{cht_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0, '0},
        '{cht_pkg::CMD_REMOVE, K0, 32'd0,         1'b0, '0},
        '{cht_pkg::CMD_LOOKUP, K0, 32'd0,         1'b0, '0}
    };

    logic [10:0] phase_cfg [] = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'd7, 11'd16};

    initial begin
        int i, p;
        buckets_cfg = cht_pkg::BUCKETS_RST;
        for (i = 0; i < MAX_BUCKETS; i++) head_link[i] = NULL_LINK;
        for (i = 0; i < NODE_COUNT; i++) begin
            shadow_hash[i] = '0;
            shadow_data[i] = '0;
            shadow_next[i] = NULL_LINK;
            free_pool[i] = i;
        end
        nodes_taken = 0;
        key_pool[0] = K0;
        key_pool[1] = K1;
        for (i = 2; i < N_KEYS; i++) key_pool[i] = {$urandom, $urandom};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[j])
            send_request(directed[j].cmd, directed[j].key, directed[j].val,
                         directed[j].typed, directed[j].r);

        for (p = 0; p < phase_cfg.size(); p++) begin
            drain();
            write_buckets(phase_cfg[p]);
            for (i = 0; i < 100; i++) begin
                // hold off mid-phase until the table has answered everything
                if (p == 1 && i == 50) drain();
                random_request(85);
            end
        end

        // fill the pool past capacity over wide buckets, then churn
        drain();
        write_buckets(11'd1024);
        for (i = 0; i < 275; i++)
            send_request(cht_pkg::CMD_INSERT, {$urandom, $urandom}, $urandom | 32'd1, 1'b0, '0);
        for (i = 0; i < 30; i++) random_request(60);

        drain();
        repeat (50) @(posedge aclk);
        $display("Covered %0d requests over %0d bucket settings, %0d results checked",
                 n_sent, phase_cfg.size() + 2, n_recv);
        $display("Hits or unlinks: %0d, pool-full inserts: %0d", n_hits, n_full);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
